>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/ddof_pkg.sv
// Types, constants and helper functions for the odometry fusion block.
`timescale 1ns / 1ps
package ddof_pkg;

   localparam int ROTATION_STEPS_DEF = 16;

   localparam logic [2:0] OP_ODOM   = 3'd0;
   localparam logic [2:0] OP_CAMERA = 3'd1;
   localparam logic [2:0] OP_FUSE   = 3'd2;
   localparam logic [2:0] OP_SNAP   = 3'd3;
   localparam logic [2:0] OP_SET    = 3'd4;

   localparam logic [2:0] CSR_DIST_PER_TICK = 3'd0;
   localparam logic [2:0] CSR_AXLE_WIDTH    = 3'd1;
   localparam logic [2:0] CSR_MAX_CAM_AGE   = 3'd2;
   localparam logic [2:0] CSR_FUSE_POS_THR  = 3'd3;
   localparam logic [2:0] CSR_FUSE_ANG_THR  = 3'd4;
   localparam logic [2:0] CSR_STRAIGHT_THR  = 3'd5;

   localparam logic [23:0] DIST_PER_TICK_RST = 24'd13107;
   localparam logic [23:0] AXLE_WIDTH_RST    = 24'd38400;
   localparam logic [31:0] MAX_CAM_AGE_RST   = 32'd10000000;
   localparam logic [23:0] FUSE_POS_THR_RST  = 24'd12800;
   localparam logic [14:0] FUSE_ANG_THR_RST  = 15'd2086;
   localparam logic [7:0]  STRAIGHT_THR_RST  = 8'd3;

   localparam logic signed [31:0] START_X       = 32'sd51200;
   localparam logic [15:0]        START_HEADING = 16'd16384;

   localparam logic signed [33:0] KINV_Q30       = 34'sd652032874;
   localparam logic [63:0]        TURN32_PER_RAD = 64'd683565276;
   localparam logic [63:0]        W_POS_Q16      = 64'd19661;
   localparam logic [63:0]        W_TURN_Q16     = 64'd32768;
   localparam logic [63:0]        W_STEADY_Q16   = 64'd6554;

   typedef enum logic [4:0] {
      S_IDLE, S_EXEC, S_COR1, S_STR_D, S_STR_X, S_STR_Y,
      S_ARC_P, S_ARC_T, S_ARC_K, S_COR2, S_ARC_Q, S_ARC_NX, S_ARC_DX,
      S_ARC_NY, S_ARC_DY, S_FUS_SX, S_FUS_SY, S_FUS_TH, S_FUS_WX,
      S_FUS_WY, S_FUS_WH, S_DONE
   } state_type;

   typedef enum logic {ALU_MUL, ALU_DIV} alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic [6:0] nbits;
   } alu_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> sv/ddof_req_if.sv
// Request channel: operation, wheel counts, given pose and time.
`timescale 1ns / 1ps
interface ddof_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [15:0] count_right;
   logic signed [15:0] count_left;
   logic signed [31:0] given_x;
   logic signed [31:0] given_y;
   logic signed [15:0] given_heading;
   logic [31:0]        now_us;

   modport source (output valid, operation, count_right, count_left, given_x, given_y,
                   given_heading, now_us, input ready);
   modport sink (input valid, operation, count_right, count_left, given_x, given_y,
                 given_heading, now_us, output ready);
endinterface

>>> sv/ddof_rsp_if.sv
// Response channel: pose estimate, fusion error and status flags.
`timescale 1ns / 1ps
interface ddof_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] est_x;
   logic signed [31:0] est_y;
   logic signed [15:0] est_heading;
   logic signed [31:0] err_x;
   logic signed [31:0] err_y;
   logic signed [15:0] err_heading;
   logic               camera_fresh;
   logic               applied;

   modport source (output valid, est_x, est_y, est_heading, err_x, err_y, err_heading,
                   camera_fresh, applied, input ready);
   modport sink (input valid, est_x, est_y, est_heading, err_x, err_y, err_heading,
                 camera_fresh, applied, output ready);
endinterface

>>> sv/diff_drive_odometry_fusion.sv
// Differential-drive odometry with camera pose fusion, top level.
`timescale 1ns / 1ps
// Keeps the pose (x, y in Q23.8 mm, heading as a 16-bit binary angle) of a
// two-wheeled robot. One request is taken at a time; ready drops while it is
// worked on and returns once its response sits in the output register, so a
// new request may enter while the previous response still waits. Camera,
// snap, set pose, the first odometry request and a stale fuse go straight to
// the finish state; other odometry steps and fresh fuses use the shared ALU,
// which multiplies one multiplier bit per cycle (16 to 34 bits per product)
// and divides one quotient bit per cycle (64 bits per quotient), and the
// CORDIC, one rotation per cycle. Configuration registers are written through
// csr_we/csr_index/csr_wdata while the block is idle, a rule for the user that
// the block itself does not enforce; indexes beyond the list are ignored.
`include "assert_macros.svh"
module diff_drive_odometry_fusion
   import ddof_pkg::*;
#(
   parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   ddof_req_if.sink      req_if,
   ddof_rsp_if.source    rsp_if
);

   // configuration
   logic [23:0] dpt_ff, axle_ff, pos_thr_ff;
   logic [31:0] max_age_ff;
   logic [14:0] ang_thr_ff;
   logic [7:0]  st_thr_ff;

   // architectural state
   logic signed [31:0] pose_x_ff, pose_y_ff, cam_x_ff, cam_y_ff;
   logic [15:0]        pose_h_ff, cam_h_ff;
   logic [31:0]        cam_time_ff;
   logic               cam_seen_ff, latched_ff;
   logic [15:0]        prev_r_ff, prev_l_ff;
   logic signed [31:0] err_x_ff, err_y_ff;
   logic [15:0]        err_h_ff;

   // request hold
   logic [2:0]         op_ff;
   logic [15:0]        cr_ff, cl_ff;
   logic signed [31:0] gx_ff, gy_ff;
   logic [15:0]        gh_ff;
   logic [31:0]        now_ff;

   // working registers
   state_type          state_ff, state_in;
   logic               launched_ff;
   logic signed [17:0] diff_ff, sum_ff;
   logic               straight_ff;
   logic signed [33:0] c1_ff, s1_ff;
   logic signed [63:0] tmp_ff, q_ff;
   logic [31:0]        th2_ff;
   logic signed [25:0] ds_ff, dc_ff;
   logic signed [32:0] ex_ff, ey_ff;
   logic [63:0]        sq_ff;
   logic               applied_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_ex_ff, rsp_ey_ff;
   logic [15:0]        rsp_h_ff, rsp_eh_ff;
   logic               rsp_fresh_ff, rsp_applied_ff;

   // shared units
   alu_ctrl_type       alu_ctrl;
   logic [63:0]        alu_a, alu_b;
   unit_stat_type      alu_stat;
   logic signed [63:0] alu_res;
   logic               cor_start;
   logic [31:0]        cor_angle;
   unit_stat_type      cor_stat;
   logic signed [33:0] cor_cos, cor_sin;

   // combinational helpers
   logic               req_take, rsp_load, is_cor_state, unit_go, step_done;
   logic               fresh_w, small_w, turn_w;
   logic [31:0]        age_w;
   logic signed [15:0] dr_w, dl_w, eh_w;
   logic signed [17:0] diff_w;
   logic [17:0]        adiff_w;
   logic [16:0]        aeh_w;
   logic [23:0]        axle_eff;
   logic signed [32:0] ex_w, ey_w;
   logic [63:0]        dth_sum;

   ddof_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opa    (alu_a),
      .opb    (alu_b),
      .stat   (alu_stat),
      .result (alu_res)
   );

   ddof_cordic #(
      .ROTATION_STEPS (ROTATION_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .stat    (cor_stat),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   // Freshness, wheel deltas and fuse errors, all from current registers.
   assign age_w    = now_ff - cam_time_ff;
   assign fresh_w  = cam_seen_ff && (age_w < max_age_ff);
   assign dr_w     = signed'(cr_ff - prev_r_ff);
   assign dl_w     = signed'(cl_ff - prev_l_ff);
   assign diff_w   = 18'(dr_w) - 18'(dl_w);
   assign adiff_w  = diff_w[17] ? unsigned'(-diff_w) : unsigned'(diff_w);
   assign axle_eff = (axle_ff == 24'd0) ? 24'd1 : axle_ff;
   assign ex_w     = 33'(cam_x_ff) - 33'(pose_x_ff);
   assign ey_w     = 33'(cam_y_ff) - 33'(pose_y_ff);
   assign eh_w     = signed'(err_h_ff);
   assign aeh_w    = eh_w[15] ? unsigned'(-17'(eh_w)) : unsigned'(17'(eh_w));
   assign small_w  = (sq_ff < unsigned'(alu_res)) && (aeh_w < 17'(ang_thr_ff));
   assign turn_w   = aeh_w > 17'(ang_thr_ff);
   assign dth_sum  = unsigned'(alu_res) + 64'd2097152;

   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_if.ready);
   assign is_cor_state = (state_ff == S_COR1) || (state_ff == S_COR2);
   assign unit_go      = (state_ff != S_IDLE) && (state_ff != S_EXEC) &&
                         (state_ff != S_DONE) && !launched_ff;
   assign step_done    = is_cor_state ? cor_stat.done : alu_stat.done;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_take) state_in = S_EXEC;
         S_EXEC: begin
            priority if (op_ff == OP_ODOM && latched_ff) begin
               state_in = S_COR1;
            end else if (op_ff == OP_FUSE && fresh_w) begin
               state_in = S_FUS_SX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_COR1:   if (step_done) state_in = straight_ff ? S_STR_D : S_ARC_P;
         S_STR_D:  if (step_done) state_in = S_STR_X;
         S_STR_X:  if (step_done) state_in = S_STR_Y;
         S_STR_Y:  if (step_done) state_in = S_DONE;
         S_ARC_P:  if (step_done) state_in = S_ARC_T;
         S_ARC_T:  if (step_done) state_in = S_ARC_K;
         S_ARC_K:  if (step_done) state_in = S_COR2;
         S_COR2:   if (step_done) state_in = S_ARC_Q;
         S_ARC_Q:  if (step_done) state_in = S_ARC_NX;
         S_ARC_NX: if (step_done) state_in = S_ARC_DX;
         S_ARC_DX: if (step_done) state_in = S_ARC_NY;
         S_ARC_NY: if (step_done) state_in = S_ARC_DY;
         S_ARC_DY: if (step_done) state_in = S_DONE;
         S_FUS_SX: if (step_done) state_in = S_FUS_SY;
         S_FUS_SY: if (step_done) state_in = S_FUS_TH;
         S_FUS_TH: if (step_done) state_in = small_w ? S_DONE : S_FUS_WX;
         S_FUS_WX: if (step_done) state_in = S_FUS_WY;
         S_FUS_WY: if (step_done) state_in = S_FUS_WH;
         S_FUS_WH: if (step_done) state_in = S_DONE;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // unit operands and handshake outputs
   always_comb begin
      alu_ctrl.start = 1'b0;
      alu_ctrl.op    = ALU_MUL;
      alu_ctrl.nbits = 7'd25;
      alu_a          = '0;
      alu_b          = '0;
      cor_start      = 1'b0;
      cor_angle      = {pose_h_ff, 16'h0000};
      unique case (state_ff)
         S_COR1: cor_start = unit_go;
         S_COR2: begin
            cor_start = unit_go;
            cor_angle = th2_ff;
         end
         S_STR_D, S_ARC_P: begin
            alu_a = 64'(state_ff == S_STR_D ? sum_ff : diff_ff);
            alu_b = 64'(dpt_ff);
         end
         S_STR_X, S_STR_Y: begin
            alu_a          = tmp_ff;
            alu_b          = 64'(state_ff == S_STR_X ? c1_ff : s1_ff);
            alu_ctrl.nbits = 7'd34;
         end
         S_ARC_T: begin
            alu_ctrl.op = ALU_DIV;
            alu_a       = tmp_ff;
            alu_b       = 64'(axle_eff);
         end
         S_ARC_K: begin
            alu_a          = tmp_ff;
            alu_b          = TURN32_PER_RAD;
            alu_ctrl.nbits = 7'd31;
         end
         S_ARC_Q: begin
            alu_a = 64'(sum_ff);
            alu_b = 64'(axle_eff);
         end
         S_ARC_NX, S_ARC_NY: begin
            alu_a          = q_ff;
            alu_b          = 64'(state_ff == S_ARC_NX ? ds_ff : dc_ff);
            alu_ctrl.nbits = 7'd26;
         end
         S_ARC_DX, S_ARC_DY: begin
            alu_ctrl.op = ALU_DIV;
            alu_a       = tmp_ff;
            alu_b       = 64'(diff_ff) <<< 22;
         end
         S_FUS_SX, S_FUS_SY: begin
            alu_a          = 64'(state_ff == S_FUS_SX ? err_x_ff : err_y_ff);
            alu_b          = alu_a;
            alu_ctrl.nbits = 7'd32;
         end
         S_FUS_TH: begin
            alu_a = 64'(pos_thr_ff);
            alu_b = 64'(pos_thr_ff);
         end
         S_FUS_WX, S_FUS_WY: begin
            alu_a          = 64'(state_ff == S_FUS_WX ? ex_ff : ey_ff);
            alu_b          = W_POS_Q16;
            alu_ctrl.nbits = 7'd16;
         end
         S_FUS_WH: begin
            alu_a          = 64'(eh_w);
            alu_b          = turn_w ? W_TURN_Q16 : W_STEADY_Q16;
            alu_ctrl.nbits = 7'd17;
         end
         default: begin
         end
      endcase
      if (!is_cor_state) begin
         alu_ctrl.start = unit_go;
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         dpt_ff       <= DIST_PER_TICK_RST;
         axle_ff      <= AXLE_WIDTH_RST;
         max_age_ff   <= MAX_CAM_AGE_RST;
         pos_thr_ff   <= FUSE_POS_THR_RST;
         ang_thr_ff   <= FUSE_ANG_THR_RST;
         st_thr_ff    <= STRAIGHT_THR_RST;
         pose_x_ff    <= START_X;
         pose_y_ff    <= '0;
         pose_h_ff    <= START_HEADING;
         cam_x_ff     <= START_X;
         cam_y_ff     <= '0;
         cam_h_ff     <= START_HEADING;
         cam_time_ff  <= '0;
         cam_seen_ff  <= 1'b0;
         prev_r_ff    <= '0;
         prev_l_ff    <= '0;
         latched_ff   <= 1'b0;
         err_x_ff     <= '0;
         err_y_ff     <= '0;
         err_h_ff     <= '0;
         state_ff     <= S_IDLE;
         launched_ff  <= 1'b0;
         applied_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // a unit is launched once per compute state; its done ends the state
         if (unit_go) begin
            launched_ff <= 1'b1;
         end else if (step_done) begin
            launched_ff <= 1'b0;
         end

         if (csr_we) begin
            unique case (csr_index)
               CSR_DIST_PER_TICK: dpt_ff     <= csr_wdata[23:0];
               CSR_AXLE_WIDTH:    axle_ff    <= csr_wdata[23:0];
               CSR_MAX_CAM_AGE:   max_age_ff <= csr_wdata;
               CSR_FUSE_POS_THR:  pos_thr_ff <= csr_wdata[23:0];
               CSR_FUSE_ANG_THR:  ang_thr_ff <= csr_wdata[14:0];
               CSR_STRAIGHT_THR:  st_thr_ff  <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end

         if (req_take) begin
            applied_ff <= 1'b0;
         end

         unique case (state_ff)
            S_EXEC: begin
               unique case (op_ff)
                  OP_ODOM: begin
                     // every odometry request latches the counts; the first one only latches
                     prev_r_ff  <= cr_ff;
                     prev_l_ff  <= cl_ff;
                     latched_ff <= 1'b1;
                  end
                  OP_CAMERA: begin
                     if (!cam_seen_ff) begin
                        pose_x_ff <= gx_ff;
                        pose_y_ff <= gy_ff;
                        pose_h_ff <= gh_ff;
                     end
                     cam_x_ff    <= gx_ff;
                     cam_y_ff    <= gy_ff;
                     cam_h_ff    <= gh_ff;
                     cam_time_ff <= now_ff;
                     cam_seen_ff <= 1'b1;
                  end
                  OP_FUSE: begin
                     // stale camera clears the error and keeps the pose
                     if (fresh_w) begin
                        err_x_ff <= sat32(65'(ex_w));
                        err_y_ff <= sat32(65'(ey_w));
                        err_h_ff <= cam_h_ff - pose_h_ff;
                     end else begin
                        err_x_ff <= '0;
                        err_y_ff <= '0;
                        err_h_ff <= '0;
                     end
                  end
                  OP_SNAP: begin
                     if (fresh_w) begin
                        pose_x_ff  <= cam_x_ff;
                        pose_y_ff  <= cam_y_ff;
                        pose_h_ff  <= cam_h_ff;
                        applied_ff <= 1'b1;
                     end
                  end
                  OP_SET: begin
                     pose_x_ff <= gx_ff;
                     pose_y_ff <= gy_ff;
                     pose_h_ff <= gh_ff;
                  end
                  default: begin
                  end
               endcase
            end
            S_STR_X: if (alu_stat.done) begin
               pose_x_ff <= sat32(65'(pose_x_ff) + 65'((alu_res + 64'sd536870912) >>> 30));
            end
            S_STR_Y: if (alu_stat.done) begin
               pose_y_ff <= sat32(65'(pose_y_ff) + 65'((alu_res + 64'sd536870912) >>> 30));
            end
            S_ARC_DX: if (alu_stat.done) begin
               pose_x_ff <= sat32(65'(pose_x_ff) + 65'(alu_res));
            end
            S_ARC_DY: if (alu_stat.done) begin
               pose_y_ff <= sat32(65'(pose_y_ff) + 65'(alu_res));
               pose_h_ff <= 16'((th2_ff + 32'h00008000) >> 16);
            end
            S_FUS_WX: if (alu_stat.done) begin
               pose_x_ff <= sat32(65'(pose_x_ff) + 65'((alu_res + 64'sd32768) >>> 16));
            end
            S_FUS_WY: if (alu_stat.done) begin
               pose_y_ff <= sat32(65'(pose_y_ff) + 65'((alu_res + 64'sd32768) >>> 16));
            end
            S_FUS_WH: if (alu_stat.done) begin
               pose_h_ff  <= pose_h_ff + 16'(unsigned'((alu_res + 64'sd32768) >>> 16));
               applied_ff <= 1'b1;
            end
            default: begin
            end
         endcase

         // response register: hold until taken, reload from the finish state
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and working registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_if.operation;
         cr_ff  <= unsigned'(req_if.count_right);
         cl_ff  <= unsigned'(req_if.count_left);
         gx_ff  <= req_if.given_x;
         gy_ff  <= req_if.given_y;
         gh_ff  <= unsigned'(req_if.given_heading);
         now_ff <= req_if.now_us;
      end
      if (state_ff == S_EXEC) begin
         diff_ff     <= diff_w;
         sum_ff      <= 18'(dr_w) + 18'(dl_w);
         straight_ff <= (diff_w == 18'sd0) || (adiff_w < 18'(st_thr_ff));
         ex_ff       <= ex_w;
         ey_ff       <= ey_w;
      end
      if (cor_stat.done && state_ff == S_COR1) begin
         c1_ff <= cor_cos;
         s1_ff <= cor_sin;
      end
      if (cor_stat.done && state_ff == S_COR2) begin
         ds_ff <= 26'((35'(cor_sin) - 35'(s1_ff)) >>> 9);
         dc_ff <= 26'((35'(c1_ff) - 35'(cor_cos)) >>> 9);
      end
      if (alu_stat.done) begin
         unique case (state_ff)
            S_STR_D:  tmp_ff <= (alu_res + 64'sd256) >>> 9;
            S_ARC_P:  tmp_ff <= alu_res <<< 14;
            S_ARC_T, S_ARC_NX, S_ARC_NY, S_FUS_SX: tmp_ff <= alu_res;
            S_ARC_K:  th2_ff <= {pose_h_ff, 16'h0000} + dth_sum[53:22];
            S_ARC_Q:  q_ff   <= alu_res;
            S_FUS_SY: sq_ff  <= unsigned'(tmp_ff) + unsigned'(alu_res);
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_x_ff       <= pose_x_ff;
         rsp_y_ff       <= pose_y_ff;
         rsp_h_ff       <= pose_h_ff;
         rsp_ex_ff      <= err_x_ff;
         rsp_ey_ff      <= err_y_ff;
         rsp_eh_ff      <= err_h_ff;
         rsp_fresh_ff   <= fresh_w;
         rsp_applied_ff <= applied_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.est_x        = rsp_x_ff;
   assign rsp_if.est_y        = rsp_y_ff;
   assign rsp_if.est_heading  = signed'(rsp_h_ff);
   assign rsp_if.err_x        = rsp_ex_ff;
   assign rsp_if.err_y        = rsp_ey_ff;
   assign rsp_if.err_heading  = signed'(rsp_eh_ff);
   assign rsp_if.camera_fresh = rsp_fresh_ff;
   assign rsp_if.applied      = rsp_applied_ff;

   // one request in flight: ready stays low right after a request is taken
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_if.ready)
   // the shared ALU is never restarted while it works
   `ASSERT_IMPLY(a_alu_idle_on_start, clock, reset, alu_ctrl.start, !alu_stat.busy)
   // only a fuse or a snap reports a correction
   `ASSERT_IMPLY(a_applied_source, clock, reset, rsp_load && applied_ff,
                 op_ff == OP_FUSE || op_ff == OP_SNAP)

endmodule

>>> sv/ddof_alu.sv
// Shared bit-serial multiplier and restoring divider, 64-bit.
`timescale 1ns / 1ps
module ddof_alu
   import ddof_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  alu_ctrl_type        ctrl,
   input  logic [63:0]         opa,
   input  logic [63:0]         opb,
   output unit_stat_type       stat,
   output logic signed [63:0]  result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   alu_op_type  op_ff, op_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;

   logic [63:0] addend;
   logic [64:0] rsh;
   logic [64:0] rdiff;
   logic [63:0] qnext;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      addend  = b_ff[0] ? a_ff : 64'd0;
      rsh     = {rem_ff, a_ff[63]};
      rdiff   = rsh - {1'b0, b_ff};
      qnext   = {a_ff[62:0], ~rdiff[64]};
      if (ctrl.start) begin
         busy_in = 1'b1;
         op_in   = ctrl.op;
         acc_in  = 64'd0;
         rem_in  = 64'd0;
         if (ctrl.op == ALU_MUL) begin
            a_in   = opa;
            b_in   = opb;
            cnt_in = ctrl.nbits - 7'd1;
            neg_in = 1'b0;
         end else begin
            a_in   = opa[63] ? (64'd0 - opa) : opa;
            b_in   = opb[63] ? (64'd0 - opb) : opb;
            cnt_in = 7'd63;
            neg_in = opa[63] ^ opb[63];
         end
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            // top multiplier bit carries negative weight
            acc_in = (cnt_ff == 7'd0) ? (acc_ff - addend) : (acc_ff + addend);
            a_in   = {a_ff[62:0], 1'b0};
            b_in   = {1'b0, b_ff[63:1]};
         end else begin
            a_in = qnext;
            if (!rdiff[64]) begin
               rem_in = rdiff[63:0];
            end else begin
               rem_in = rsh[63:0];
            end
            if (cnt_ff == 7'd0) begin
               acc_in = neg_ff ? (64'd0 - qnext) : qnext;
            end
         end
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = signed'(acc_ff);

endmodule

>>> sv/ddof_cordic.sv
// Iterative rotation CORDIC: cosine and sine of a 32-bit turn angle in Q30.
`timescale 1ns / 1ps
module ddof_cordic
   import ddof_pkg::*;
#(
   parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output unit_stat_type       stat,
   output logic signed [33:0]  cos_out,
   output logic signed [33:0]  sin_out
);

   localparam int IW = $clog2(ROTATION_STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 flip_ff, flip_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic signed [33:0]   x_ff, x_in;
   logic signed [33:0]   y_ff, y_in;
   logic signed [33:0]   z_ff, z_in;

   logic                 flip_w;
   logic [31:0]          ang_w;
   logic signed [33:0]   dx, dy, at;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_w  = angle[31] ^ angle[30];
      ang_w   = flip_w ? (angle + 32'h80000000) : angle;
      dx      = y_ff >>> idx_ff;
      dy      = x_ff >>> idx_ff;
      at      = signed'(34'(atan_turn(5'(idx_ff))));
      if (start) begin
         busy_in = 1'b1;
         flip_in = flip_w;
         idx_in  = '0;
         x_in    = KINV_Q30;
         y_in    = '0;
         z_in    = 34'(signed'(ang_w));
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         if (idx_ff == IW'(ROTATION_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign cos_out   = flip_ff ? -x_ff : x_ff;
   assign sin_out   = flip_ff ? -y_ff : y_ff;

endmodule

>>> tb/sv/tb_diff_drive_odometry_fusion.sv
// Testbench for the differential-drive odometry fusion block.
`timescale 1ns / 1ps
module tb_diff_drive_odometry_fusion;
   import ddof_pkg::*;

   // Operation codes the block ignores, and register indexes past the list.
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 500;    // longer than one arc step
   localparam int HOLD_CYCLES = 600;     // long receiver stall
   localparam int ITEMS_PER_PHASE = 300;

   typedef struct {
      logic [2:0]         operation;
      logic signed [15:0] count_right;
      logic signed [15:0] count_left;
      logic signed [31:0] given_x;
      logic signed [31:0] given_y;
      logic signed [15:0] given_heading;
      logic [31:0]        now_us;
   } pose_req_t;

   typedef struct {
      logic signed [31:0] est_x;
      logic signed [31:0] est_y;
      logic signed [15:0] est_heading;
      logic signed [31:0] err_x;
      logic signed [31:0] err_y;
      logic signed [15:0] err_heading;
      logic               camera_fresh;
      logic               applied;
   } pose_rsp_t;

   // Pose tracker: keeps its own pose, camera and register copies and queues
   // the response expected for every accepted request.
   class pose_tracker;
      logic [23:0] dist_per_tick, axle_width, pos_thr;
      logic [31:0] max_age;
      logic [14:0] ang_thr;
      logic [7:0]  straight_thr;
      logic signed [31:0] px, py, cx, cy;
      logic [15:0] ph, ch;
      logic [31:0] cam_time;
      bit cam_seen, latched;
      logic [15:0] last_r, last_l;
      logic signed [31:0] ex_q, ey_q;
      logic signed [15:0] eh_q;
      pose_rsp_t pending[$];
      int errors;
      int checked;
      logic [31:0] atan_tab[24];

      function new();
         atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
         dist_per_tick = DIST_PER_TICK_RST;
         axle_width = AXLE_WIDTH_RST;
         max_age = MAX_CAM_AGE_RST;
         pos_thr = FUSE_POS_THR_RST;
         ang_thr = FUSE_ANG_THR_RST;
         straight_thr = STRAIGHT_THR_RST;
         px = START_X; cx = START_X; py = 0; cy = 0;
         ph = START_HEADING; ch = START_HEADING;
         cam_time = 0; cam_seen = 0; latched = 0;
         last_r = 0; last_l = 0;
         ex_q = 0; ey_q = 0; eh_q = 0;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_DIST_PER_TICK: dist_per_tick = v[23:0];
            CSR_AXLE_WIDTH:    axle_width = v[23:0];
            CSR_MAX_CAM_AGE:   max_age = v;
            CSR_FUSE_POS_THR:  pos_thr = v[23:0];
            CSR_FUSE_ANG_THR:  ang_thr = v[14:0];
            CSR_STRAIGHT_THR:  straight_thr = v[7:0];
            default: ;
         endcase
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      // Rotation CORDIC on a 32-bit turn angle; Q30 cosine and sine.
      function void rotate(logic [31:0] ang, output longint c, output longint s);
         logic [31:0] a;
         bit flip;
         longint x, y, z, sx, sy;
         a = ang;
         flip = (((a + 32'h40000000) & 32'h80000000) != 0);
         if (flip) a = a + 32'h80000000;
         x = 652032874; y = 0;
         z = longint'($signed(a));
         for (int i = 0; i < ROTATION_STEPS_DEF && i < 24; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (z >= 0) begin
               x = x - sx; y = y + sy; z = z - longint'(atan_tab[i]);
            end else begin
               x = x + sx; y = y - sy; z = z + longint'(atan_tab[i]);
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function bit fresh_at(logic [31:0] now);
         logic [31:0] age;
         age = now - cam_time;
         return cam_seen && (age < max_age);
      endfunction

      function void advance_odometry(logic [15:0] cr, logic [15:0] cl);
         logic [15:0] wr, wl;
         logic [31:0] th1, th2, dth;
         longint dr, dl, diff, adiff, total, c1, s1, c2, s2, d, axle, t, den, ds, dc;
         longint unsigned u;
         th1 = {ph, 16'h0000};
         if (!latched) begin
            last_r = cr; last_l = cl; latched = 1;
            return;
         end
         wr = cr - last_r;
         wl = cl - last_l;
         dr = longint'($signed(wr));
         dl = longint'($signed(wl));
         last_r = cr; last_l = cl;
         diff = dr - dl;
         adiff = diff < 0 ? -diff : diff;
         total = dr + dl;
         rotate(th1, c1, s1);
         if (diff == 0 || adiff < longint'(straight_thr)) begin
            d = (total * longint'(dist_per_tick) + 256) >>> 9;
            px = clamp32(longint'(px) + ((d * c1 + (64'sd1 <<< 29)) >>> 30));
            py = clamp32(longint'(py) + ((d * s1 + (64'sd1 <<< 29)) >>> 30));
         end else begin
            axle = (axle_width != 0) ? longint'(axle_width) : 1;
            t = (diff * longint'(dist_per_tick) * 16384) / axle;
            u = longint'(t) * 64'd683565276 + (64'd1 << 21);
            dth = u[53:22];
            th2 = th1 + dth;
            den = diff * 4194304;
            rotate(th2, c2, s2);
            ds = (s2 - s1) >>> 9;
            dc = (c1 - c2) >>> 9;
            px = clamp32(longint'(px) + (total * axle * ds) / den);
            py = clamp32(longint'(py) + (total * axle * dc) / den);
            th2 = th2 + 32'h8000;
            ph = th2[31:16];
         end
      endfunction

      function bit fuse_toward_camera(bit fresh);
         longint ex, ey, eh, aeh, w, ax, ay, step;
         longint unsigned sq, thr;
         logic [15:0] hd;
         if (!fresh) begin
            ex_q = 0; ey_q = 0; eh_q = 0;
            return 0;
         end
         ex = longint'(cx) - longint'(px);
         ey = longint'(cy) - longint'(py);
         hd = ch - ph;
         eh = longint'($signed(hd));
         ex_q = clamp32(ex);
         ey_q = clamp32(ey);
         eh_q = hd;
         ax = longint'(ex_q); ay = longint'(ey_q);
         sq = longint'(ax * ax) + longint'(ay * ay);
         thr = longint'(pos_thr) * longint'(pos_thr);
         aeh = eh < 0 ? -eh : eh;
         if (sq < thr && aeh < longint'(ang_thr)) return 0;
         w = (aeh > longint'(ang_thr)) ? 32768 : 6554;
         px = clamp32(longint'(px) + ((ex * 19661 + 32768) >>> 16));
         py = clamp32(longint'(py) + ((ey * 19661 + 32768) >>> 16));
         step = (eh * w + 32768) >>> 16;
         ph = ph + step[15:0];
         return 1;
      endfunction

      function void note_request(pose_req_t r);
         pose_rsp_t e;
         bit hit;
         hit = 0;
         case (r.operation)
            OP_ODOM: advance_odometry(r.count_right, r.count_left);
            OP_CAMERA: begin
               if (!cam_seen) begin
                  px = r.given_x; py = r.given_y; ph = r.given_heading;
               end
               cx = r.given_x; cy = r.given_y; ch = r.given_heading;
               cam_time = r.now_us;
               cam_seen = 1;
            end
            OP_FUSE: hit = fuse_toward_camera(fresh_at(r.now_us));
            OP_SNAP: begin
               if (fresh_at(r.now_us)) begin
                  px = cx; py = cy; ph = ch; hit = 1;
               end
            end
            OP_SET: begin
               px = r.given_x; py = r.given_y; ph = r.given_heading;
            end
            default: ;
         endcase
         e.est_x = px; e.est_y = py; e.est_heading = ph;
         e.err_x = ex_q; e.err_y = ey_q; e.err_heading = eh_q;
         e.camera_fresh = fresh_at(r.now_us);
         e.applied = hit;
         pending.push_back(e);
      endfunction

      task report(string field, longint got, longint want);
         errors++;
         $display("MISMATCH response %0d %s: got %0d expected %0d",
                  checked, field, got, want);
      endtask

      task check_response(pose_rsp_t g);
         pose_rsp_t e;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         e = pending.pop_front();
         if (g.est_x !== e.est_x) report("est_x", g.est_x, e.est_x);
         if (g.est_y !== e.est_y) report("est_y", g.est_y, e.est_y);
         if (g.est_heading !== e.est_heading)
            report("est_heading", g.est_heading, e.est_heading);
         if (g.err_x !== e.err_x) report("err_x", g.err_x, e.err_x);
         if (g.err_y !== e.err_y) report("err_y", g.err_y, e.err_y);
         if (g.err_heading !== e.err_heading)
            report("err_heading", g.err_heading, e.err_heading);
         if (g.camera_fresh !== e.camera_fresh)
            report("camera_fresh", g.camera_fresh, e.camera_fresh);
         if (g.applied !== e.applied) report("applied", g.applied, e.applied);
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   ddof_req_if req_if ();
   ddof_rsp_if rsp_if ();

   diff_drive_odometry_fusion uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source)
   );

   pose_tracker tracker;
   int          cycle_count;
   bit          hold_request;    // ask the receiver for one long stall
   int          sent;
   int          arcs_sent, fuses_sent;

   // Stimulus state: running encoder counts and the microsecond clock.
   logic [15:0] enc_r, enc_l;
   logic [31:0] t_now;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold on request; check each response.
   initial begin : receiver
      int gap;
      pose_rsp_t got;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (hold_request) begin
            // Hold ready low long enough for the block to stall its input.
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 0;
         end else if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.est_x = rsp_if.est_x;
         got.est_y = rsp_if.est_y;
         got.est_heading = rsp_if.est_heading;
         got.err_x = rsp_if.err_x;
         got.err_y = rsp_if.err_y;
         got.err_heading = rsp_if.err_heading;
         got.camera_fresh = rsp_if.camera_fresh;
         got.applied = rsp_if.applied;
         tracker.check_response(got);
      end
   end

   // Offer one request after a random gap; hold it until accepted.
   task send_request(pose_req_t r, bit no_gap);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operation <= r.operation;
      req_if.count_right <= r.count_right;
      req_if.count_left <= r.count_left;
      req_if.given_x <= r.given_x;
      req_if.given_y <= r.given_y;
      req_if.given_heading <= r.given_heading;
      req_if.now_us <= r.now_us;
      do @(posedge clock); while (!req_if.ready);
      tracker.note_request(r);
      sent++;
      if (r.operation == OP_ODOM && r.count_right != r.count_left) arcs_sent++;
      if (r.operation == OP_FUSE) fuses_sent++;
   endtask

   // Drop valid and wait until every expected response is back.
   task drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One write cycle, then csr_we is dropped again before the next write.
   task csr_write(logic [2:0] idx, logic [31:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, v);
      @(posedge clock);
   endtask

   function pose_req_t blank_req(logic [2:0] op);
      pose_req_t r;
      r.operation = op;
      r.count_right = enc_r;
      r.count_left = enc_l;
      r.given_x = $urandom;
      r.given_y = $urandom;
      r.given_heading = $urandom;
      r.now_us = t_now;
      return r;
   endfunction

   function pose_req_t random_req();
      pose_req_t r;
      int pick, dr, dl;
      pick = $urandom_range(0, 99);
      // Advance time mostly a little, sometimes far enough to go stale.
      if ($urandom_range(0, 24) == 0) t_now = t_now + $urandom;
      else t_now = t_now + $urandom_range(0, 3000);
      if (pick < 48) begin
         r = blank_req(OP_ODOM);
         case ($urandom_range(0, 9))
            0: begin enc_r = $urandom; enc_l = $urandom; end
            1, 2, 3: begin
               dr = $urandom_range(0, 400) - 200;
               enc_r = enc_r + dr[15:0];
               enc_l = enc_l + dr[15:0] + $urandom_range(0, 4) - 2;
            end
            default: begin
               dr = $urandom_range(0, 600) - 300;
               dl = $urandom_range(0, 600) - 300;
               enc_r = enc_r + dr[15:0];
               enc_l = enc_l + dl[15:0];
            end
         endcase
         r.count_right = enc_r;
         r.count_left = enc_l;
      end else if (pick < 60) begin
         r = blank_req(OP_CAMERA);
         if ($urandom_range(0, 3) != 0) begin
            // Camera near the estimate, so fusion sees small and large errors.
            r.given_x = tracker.px + $signed($urandom_range(0, 40000)) - 20000;
            r.given_y = tracker.py + $signed($urandom_range(0, 40000)) - 20000;
            r.given_heading = tracker.ph + $urandom_range(0, 8000) - 4000;
         end
      end else if (pick < 80) r = blank_req(OP_FUSE);
      else if (pick < 89) r = blank_req(OP_SNAP);
      else if (pick < 95) r = blank_req(OP_SET);
      else r = blank_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
      return r;
   endfunction

   task directed_part;
      pose_req_t r;
      r = blank_req(OP_FUSE); send_request(r, 0);          // fuse before any camera
      r = blank_req(OP_SNAP); send_request(r, 0);          // snap before any camera
      enc_r = 16'h7FFF; enc_l = 16'h8000;
      r = blank_req(OP_ODOM); send_request(r, 0);          // first counts only latch
      enc_r = 16'h8000; enc_l = 16'h8001;
      r = blank_req(OP_ODOM); send_request(r, 1);          // wrapped deltas
      enc_r = enc_r + 16'd50; enc_l = enc_l + 16'd50;
      r = blank_req(OP_ODOM); send_request(r, 0);          // straight
      enc_r = enc_r + 16'd120; enc_l = enc_l + 16'd20;
      r = blank_req(OP_ODOM); send_request(r, 0);          // arc
      r = blank_req(OP_CAMERA);                            // first camera sets pose
      r.given_x = 32'sh7FFFFFFF; r.given_y = 32'sh80000000; r.given_heading = 16'sh8000;
      send_request(r, 0);
      r = blank_req(OP_SET); r.given_x = 0; r.given_y = 0; r.given_heading = 0;
      send_request(r, 1);
      r = blank_req(OP_FUSE); send_request(r, 0);          // huge error
      r = blank_req(OP_SNAP); send_request(r, 0);          // fresh snap
      r = blank_req(OP_CAMERA); r.given_x = tracker.px + 10; r.given_y = tracker.py - 10;
      r.given_heading = tracker.ph + 5; send_request(r, 0);
      r = blank_req(OP_FUSE); send_request(r, 0);          // error under both thresholds
      r = blank_req(OP_CAMERA); r.given_x = tracker.px; r.given_y = tracker.py;
      r.given_heading = tracker.ph + 16'd9000; send_request(r, 0);
      r = blank_req(OP_FUSE); send_request(r, 0);          // turning weight
      r = blank_req(OP_SET); r.given_x = 32'sh7FFFFF00; r.given_y = 32'sh80000100;
      r.given_heading = 16'sh0000; send_request(r, 0);
      enc_r = enc_r + 16'd30000; enc_l = enc_l + 16'd30000;
      r = blank_req(OP_ODOM); send_request(r, 0);          // position saturates
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
         r = blank_req(3'(op)); send_request(r, 0);        // ignored operations
      end
      t_now = t_now + 32'd20000000;
      r = blank_req(OP_FUSE); send_request(r, 0);          // stale fuse clears error
      r = blank_req(OP_SNAP); send_request(r, 0);          // stale snap
      t_now = 32'hFFFFFFF0;
      r = blank_req(OP_CAMERA); send_request(r, 0);
      t_now = 32'h00000010;
      r = blank_req(OP_FUSE); send_request(r, 0);          // age wraps past zero
      drain();
   endtask

   task random_part(int count, bit with_hold);
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 2) hold_request = 1;
         send_request(random_req(), 0);
      end
      drain();
   endtask

   initial begin : main
      tracker = new();
      cycle_count = 0;
      hold_request = 0;
      sent = 0; arcs_sent = 0; fuses_sent = 0;
      enc_r = 0; enc_l = 0; t_now = 0;
      reset <= 1'b1;
      csr_we <= 1'b0; csr_index <= CSR_DIST_PER_TICK; csr_wdata <= '0;
      req_if.valid <= 1'b0; req_if.operation <= OP_ODOM;
      req_if.count_right <= '0; req_if.count_left <= '0;
      req_if.given_x <= '0; req_if.given_y <= '0; req_if.given_heading <= '0;
      req_if.now_us <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Defaults after reset.
      directed_part();
      random_part(ITEMS_PER_PHASE, 1);

      // Smallest settings; zero axle acts as one, spare indexes are ignored.
      csr_write(CSR_DIST_PER_TICK, 32'd1);
      csr_write(CSR_AXLE_WIDTH, 32'd0);
      csr_write(CSR_MAX_CAM_AGE, 32'd1);
      csr_write(CSR_FUSE_POS_THR, 32'd0);
      csr_write(CSR_FUSE_ANG_THR, 32'd0);
      csr_write(CSR_STRAIGHT_THR, 32'd0);
      csr_write(CSR_SPARE_LO, $urandom);
      csr_write(CSR_SPARE_HI, $urandom);
      random_part(ITEMS_PER_PHASE, 0);

      // Largest settings.
      csr_write(CSR_DIST_PER_TICK, 32'hFFFFFFFF);
      csr_write(CSR_AXLE_WIDTH, 32'hFFFFFFFF);
      csr_write(CSR_MAX_CAM_AGE, 32'hFFFFFFFF);
      csr_write(CSR_FUSE_POS_THR, 32'hFFFFFFFF);
      csr_write(CSR_FUSE_ANG_THR, 32'hFFFFFFFF);
      csr_write(CSR_STRAIGHT_THR, 32'hFFFFFFFF);
      random_part(ITEMS_PER_PHASE, 0);

      // Narrow axle, fast wheels, straight threshold one.
      csr_write(CSR_DIST_PER_TICK, 32'd400000);
      csr_write(CSR_AXLE_WIDTH, 32'd256);
      csr_write(CSR_MAX_CAM_AGE, 32'd5000);
      csr_write(CSR_FUSE_POS_THR, 32'd3000);
      csr_write(CSR_FUSE_ANG_THR, 32'd500);
      csr_write(CSR_STRAIGHT_THR, 32'd1);
      random_part(ITEMS_PER_PHASE, 1);

      // Random mid-range settings.
      csr_write(CSR_DIST_PER_TICK, $urandom_range(1, 32'hFFFFFF));
      csr_write(CSR_AXLE_WIDTH, $urandom_range(256, 32'hFFFFFF));
      csr_write(CSR_MAX_CAM_AGE, $urandom_range(1000, 100000));
      csr_write(CSR_FUSE_POS_THR, $urandom_range(0, 50000));
      csr_write(CSR_FUSE_ANG_THR, $urandom_range(0, 32767));
      csr_write(CSR_STRAIGHT_THR, $urandom_range(1, 255));
      random_part(ITEMS_PER_PHASE, 0);

      // Back to the reset values.
      csr_write(CSR_DIST_PER_TICK, DIST_PER_TICK_RST);
      csr_write(CSR_AXLE_WIDTH, AXLE_WIDTH_RST);
      csr_write(CSR_MAX_CAM_AGE, MAX_CAM_AGE_RST);
      csr_write(CSR_FUSE_POS_THR, FUSE_POS_THR_RST);
      csr_write(CSR_FUSE_ANG_THR, FUSE_ANG_THR_RST);
      csr_write(CSR_STRAIGHT_THR, STRAIGHT_THR_RST);
      random_part(ITEMS_PER_PHASE, 0);

      $display("covered %0d requests (%0d unequal-wheel odometry, %0d fuses), %0d checked",
               sent, arcs_sent, fuses_sent, tracker.checked);
      $display("six register settings incl. both extremes, with a long output stall");
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
